>>> rtl/tensor_axis_reverse_addresser_top_macros.svh
// Assertion macros shared by the reverse addresser modules.
`ifndef TENSOR_AXIS_REVERSE_ADDRESSER_TOP_MACROS_SVH
`define TENSOR_AXIS_REVERSE_ADDRESSER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define TAR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define TAR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/tar_pkg.sv
// Shared constants, register codes and control struct of the reverse addresser.
`default_nettype none
package tar_pkg;

  // Default parameter values.
  localparam int unsigned MAX_RANK_DEF    = 8;
  localparam int unsigned DATA_WIDTH_DEF  = 64;
  localparam int unsigned INDEX_WIDTH_DEF = 32;

  // Fixed field widths of the register layout and the ports.
  localparam int unsigned NUM_DIMS    = 8;
  localparam int unsigned EXT_W       = 16;
  localparam int unsigned RANK_W      = 4;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned OUT_INDEX_W = 32;

  // Every extent is one after reset.
  localparam logic [CFG_DATA_W-1:0] EXT_RESET = 64'h0001_0001_0001_0001;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK   = 4'd0,
    REG_MASK   = 4'd1,
    REG_EXT_LO = 4'd2,
    REG_EXT_HI = 4'd3
  } tar_reg_e;

  // Control and status from the configuration sequencer to the walker.
  typedef struct packed {
    logic                             busy;
    logic                             restart;
    logic                             load;
    logic [RANK_W-1:0]                used_rank;
    logic [NUM_DIMS-1:0][EXT_W-1:0]   ext_m1;
  } tar_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/tar_cfg_seq.sv
// Configuration registers and the sequencer that derives strides and index steps.
`default_nettype none
`include "tensor_axis_reverse_addresser_top_macros.svh"
module tar_cfg_seq #(
  parameter int unsigned MAX_RANK    = tar_pkg::MAX_RANK_DEF,
  parameter int unsigned INDEX_WIDTH = tar_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [tar_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  wire logic [tar_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  output tar_pkg::tar_ctrl_t                           ctrl_o,
  output logic      [MAX_RANK-1:0][INDEX_WIDTH-1:0]    delta_o,
  output logic      [INDEX_WIDTH-1:0]                  base_o
);

  localparam int unsigned DIM_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned RW    = tar_pkg::RANK_W;
  localparam int unsigned EW    = tar_pkg::EXT_W;
  localparam int unsigned IW    = INDEX_WIDTH;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_MUL,
    SEQ_ACC,
    SEQ_LOAD
  } seq_state_e;

  seq_state_e                             state_q;
  logic [RW-1:0]                          rank_q;
  logic [tar_pkg::MASK_W-1:0]             mask_q;
  logic [tar_pkg::CFG_DATA_W-1:0]         ext_lo_q;
  logic [tar_pkg::CFG_DATA_W-1:0]         ext_hi_q;
  logic [DIM_W-1:0]                       dim_q;
  logic [IW-1:0]                          stride_q;
  logic [IW-1:0]                          prod_q;
  logic [IW-1:0]                          wsum_q;
  logic [IW-1:0]                          base_q;
  logic [MAX_RANK-1:0][IW-1:0]            delta_q;

  logic [2*tar_pkg::CFG_DATA_W-1:0]       ext_all;
  logic [tar_pkg::NUM_DIMS-1:0][EW-1:0]   ext_m1;
  logic [MAX_RANK-1:0][EW-1:0]            ext_u;
  logic [MAX_RANK-1:0]                    rev_u;
  logic [RW-1:0]                          used_rank;
  logic [RW-1:0]                          rank_m1;
  logic                                   restart;
  logic [IW+EW-1:0]                       mul_full;
  logic [IW-1:0]                          wrap;

  // Clamp extents: a zero extent counts as one.
  always_comb begin
    logic [EW-1:0] raw;
    ext_all = {ext_hi_q, ext_lo_q};
    for (int d = 0; d < tar_pkg::NUM_DIMS; d++) begin
      raw       = ext_all[d*EW +: EW];
      ext_m1[d] = (raw == '0) ? '0 : raw - EW'(1);
    end
    for (int d = 0; d < MAX_RANK; d++) begin
      raw      = ext_all[d*EW +: EW];
      ext_u[d] = (raw == '0) ? EW'(1) : raw;
      rev_u[d] = mask_q[d];
    end
  end

  // Rank zero acts as one, and ranks above the maximum saturate.
  always_comb begin
    if (rank_q == '0) begin
      used_rank = RW'(1);
    end else if (rank_q > RW'(MAX_RANK)) begin
      used_rank = RW'(MAX_RANK);
    end else begin
      used_rank = rank_q;
    end
    rank_m1 = used_rank - RW'(1);
  end

  // A write to a listed register restarts the tensor.
  assign restart = cfg_we_i && (cfg_idx_i inside {tar_pkg::REG_RANK, tar_pkg::REG_MASK,
                                                  tar_pkg::REG_EXT_LO, tar_pkg::REG_EXT_HI});

  // One stride product per step; its result is registered before use.
  assign mul_full = {{EW{1'b0}}, stride_q} * {{IW{1'b0}}, ext_u[dim_q]};

  // (extent - 1) * stride equals the next stride minus this one.
  assign wrap = prod_q - stride_q;

  // Registers and sequencer, walking from the fastest dimension to dimension zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      rank_q   <= RW'(1);
      mask_q   <= '0;
      ext_lo_q <= tar_pkg::EXT_RESET;
      ext_hi_q <= tar_pkg::EXT_RESET;
      dim_q    <= '0;
      stride_q <= IW'(1);
      prod_q   <= '0;
      wsum_q   <= '0;
      base_q   <= '0;
      delta_q  <= '0;
    end else if (restart) begin
      case (cfg_idx_i)
        tar_pkg::REG_RANK:   rank_q   <= cfg_wdata_i[RW-1:0];
        tar_pkg::REG_MASK:   mask_q   <= cfg_wdata_i[tar_pkg::MASK_W-1:0];
        tar_pkg::REG_EXT_LO: ext_lo_q <= cfg_wdata_i;
        tar_pkg::REG_EXT_HI: ext_hi_q <= cfg_wdata_i;
        default: ;
      endcase
      state_q <= SEQ_START;
    end else begin
      case (state_q)
        SEQ_START: begin
          dim_q    <= rank_m1[DIM_W-1:0];
          stride_q <= IW'(1);
          wsum_q   <= '0;
          base_q   <= '0;
          state_q  <= SEQ_MUL;
        end
        SEQ_MUL: begin
          prod_q  <= mul_full[IW-1:0];
          state_q <= SEQ_ACC;
        end
        SEQ_ACC: begin
          // Step for incrementing this dimension, with every faster one wrapping.
          delta_q[dim_q] <= rev_u[dim_q] ? wsum_q - stride_q : wsum_q + stride_q;
          wsum_q         <= rev_u[dim_q] ? wsum_q + wrap : wsum_q - wrap;
          if (rev_u[dim_q]) begin
            base_q <= base_q + wrap;
          end
          stride_q <= prod_q;
          if (dim_q == '0) begin
            state_q <= SEQ_LOAD;
          end else begin
            dim_q   <= dim_q - DIM_W'(1);
            state_q <= SEQ_MUL;
          end
        end
        SEQ_LOAD: state_q <= SEQ_IDLE;
        default:  state_q <= SEQ_IDLE;
      endcase
    end
  end

  assign ctrl_o.busy      = (state_q != SEQ_IDLE);
  assign ctrl_o.restart   = restart;
  assign ctrl_o.load      = (state_q == SEQ_LOAD);
  assign ctrl_o.used_rank = used_rank;
  assign ctrl_o.ext_m1    = ext_m1;
  assign delta_o          = delta_q;
  assign base_o           = base_q;

  // A register write always starts a recompute.
  `TAR_ASSERT_NEXT(a_restart_busy, restart, ctrl_o.busy, "write did not start the sequencer")
  // The start index is only touched by the sequencer.
  `TAR_ASSERT_NEXT(a_base_steady, (state_q == SEQ_IDLE) && !restart, $stable(base_q),
                   "start index changed while idle")
  // The load cycle hands control back to the element stream.
  `TAR_ASSERT_NEXT(a_load_idle, (state_q == SEQ_LOAD) && !restart, state_q == SEQ_IDLE,
                   "sequencer did not return to idle after the load cycle")

endmodule
`default_nettype wire

>>> rtl/tar_walker.sv
// Coordinate odometer, running destination index and result register.
`default_nettype none
`include "tensor_axis_reverse_addresser_top_macros.svh"
module tar_walker #(
  parameter int unsigned MAX_RANK    = tar_pkg::MAX_RANK_DEF,
  parameter int unsigned DATA_WIDTH  = tar_pkg::DATA_WIDTH_DEF,
  parameter int unsigned INDEX_WIDTH = tar_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire tar_pkg::tar_ctrl_t                    ctrl_i,
  input  wire logic [MAX_RANK-1:0][INDEX_WIDTH-1:0]  delta_i,
  input  wire logic [INDEX_WIDTH-1:0]                base_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [DATA_WIDTH-1:0]                 element_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [tar_pkg::OUT_INDEX_W-1:0]            target_index_o,
  output logic [DATA_WIDTH-1:0]                      moved_value_o,
  output logic                                       last_element_o
);

  localparam int unsigned RW = tar_pkg::RANK_W;
  localparam int unsigned EW = tar_pkg::EXT_W;
  localparam int unsigned IW = INDEX_WIDTH;
  localparam int unsigned OW = tar_pkg::OUT_INDEX_W;

  logic [MAX_RANK-1:0][EW-1:0]  cnt_q;
  logic [MAX_RANK-1:0][EW-1:0]  cnt_d;
  logic [IW-1:0]                tgt_q;
  logic [IW-1:0]                tgt_d;
  logic                         out_valid_q;
  logic [OW-1:0]                target_q;
  logic [DATA_WIDTH-1:0]        value_q;
  logic                         last_q;

  logic [MAX_RANK-1:0]          at_max;
  logic [MAX_RANK-1:0]          tail_max;
  logic [MAX_RANK-1:0]          sel;
  logic                         last;
  logic [IW-1:0]                delta_sel;
  logic [IW+OW-1:0]             tgt_wide;
  logic                         accept;

  // Handshake: take an item unless recomputing or the result register is held.
  assign in_stall_o = ctrl_i.busy || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Which coordinates sit at their top value; unused dimensions count as at the top.
  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      at_max[d] = (RW'(d) >= ctrl_i.used_rank) || (cnt_q[d] == ctrl_i.ext_m1[d]);
    end
    tail_max[MAX_RANK-1] = 1'b1;
    for (int d = MAX_RANK - 2; d >= 0; d--) begin
      tail_max[d] = tail_max[d+1] & at_max[d+1];
    end
    last = tail_max[0] & at_max[0];
  end

  // The dimension that increments, and the index step that goes with it.
  always_comb begin
    delta_sel = '0;
    for (int d = 0; d < MAX_RANK; d++) begin
      sel[d]    = !at_max[d] && tail_max[d];
      delta_sel = delta_sel | (sel[d] ? delta_i[d] : '0);
    end
  end

  // Next odometer value and next destination index.
  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      if (last || (tail_max[d] && at_max[d])) begin
        cnt_d[d] = '0;
      end else if (sel[d]) begin
        cnt_d[d] = cnt_q[d] + EW'(1);
      end else begin
        cnt_d[d] = cnt_q[d];
      end
    end
    tgt_d = last ? base_i : tgt_q + delta_sel;
  end

  // Control state: odometer, running index, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tgt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.restart) begin
        cnt_q <= '0;
        tgt_q <= '0;
      end else if (ctrl_i.load) begin
        tgt_q <= base_i;
      end else if (accept) begin
        cnt_q <= cnt_d;
        tgt_q <= tgt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  assign tgt_wide = {{OW{1'b0}}, tgt_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q <= tgt_wide[OW-1:0];
      value_q  <= element_value_i;
      last_q   <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_index_o = target_q;
  assign moved_value_o  = value_q;
  assign last_element_o = last_q;

  // Exactly one dimension increments on every item that is not the last.
  `TAR_ASSERT_IMP(a_one_step, accept && !last, $onehot(sel), "increment dimension not unique")
  // After the final element the index goes back to the start index.
  `TAR_ASSERT_NEXT(a_wrap_base, accept && last && !ctrl_i.restart && !ctrl_i.load,
                   tgt_q == base_i, "index did not wrap to the start index")
  // A register write starts a new tensor.
  `TAR_ASSERT_NEXT(a_restart_clear, ctrl_i.restart, (cnt_q == '0) && (tgt_q == '0),
                   "odometer not cleared by a register write")

endmodule
`default_nettype wire

>>> rtl/tensor_axis_reverse_addresser_top.sv
// Top level of the tensor axis reverse addresser.
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless a recompute or a held result stalls;
// the odometer and index update are incremental. A register write stalls input
// while the stride sequencer runs a 16-bit by index-width multiply per dimension.
// Reset: asynchronous, active low; rank 1, no reversal, all extents one.
`default_nettype none
module tensor_axis_reverse_addresser_top #(
  parameter int unsigned MAX_RANK    = tar_pkg::MAX_RANK_DEF,
  parameter int unsigned DATA_WIDTH  = tar_pkg::DATA_WIDTH_DEF,
  parameter int unsigned INDEX_WIDTH = tar_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tar_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tar_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [DATA_WIDTH-1:0]              element_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [tar_pkg::OUT_INDEX_W-1:0]         target_index_o,
  output logic [DATA_WIDTH-1:0]                   moved_value_o,
  output logic                                    last_element_o
);

  tar_pkg::tar_ctrl_t                     ctrl;
  logic [MAX_RANK-1:0][INDEX_WIDTH-1:0]   delta;
  logic [INDEX_WIDTH-1:0]                 base;

  // Configuration registers and stride sequencer.
  tar_cfg_seq #(
    .MAX_RANK    (MAX_RANK),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_cfg_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_o      (ctrl),
    .delta_o     (delta),
    .base_o      (base)
  );

  // Element stream: odometer, index and result register.
  tar_walker #(
    .MAX_RANK    (MAX_RANK),
    .DATA_WIDTH  (DATA_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .delta_i         (delta),
    .base_i          (base),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .target_index_o  (target_index_o),
    .moved_value_o   (moved_value_o),
    .last_element_o  (last_element_o)
  );

endmodule
`default_nettype wire
